>>> rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: text console writer shared definitions
// Field widths, character codes, register indexes and the command word that
// the front end hands to the back end through the queue.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int ROWF_W  = 5;
    localparam int COLF_W  = 7;
    localparam int COLOR_W = 4;
    localparam int CELL_W  = 16;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam int QDEPTH   = 4;
    localparam int TAB_STEP = 4;

    localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    localparam logic [CFG_IDX_W-1:0] REG_FG = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG = 8'd1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    typedef enum logic [2:0] {
        K_PUT,
        K_NEWLINE,
        K_RETURN,
        K_TAB,
        K_CLEAR,
        K_READ,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  ch;
        logic [ROWF_W-1:0]  row;
        logic [COLF_W-1:0]  col;
        logic               rd_ok;
    } t_cmd;

endpackage

>>> rtl/core/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front: input word decode
// Takes input words, sorts them into command kinds, range-checks read
// coordinates and pushes the result into the command queue.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [FUNC_W-1:0]    i_s_tuser,
    input  logic                 i_init_busy,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output t_cmd                 o_q_cmd
);

    logic [CHAR_W-1:0] w_ch;
    logic [ROWF_W-1:0] w_row;
    logic [COLF_W-1:0] w_col;

    assign w_ch  = i_s_tdata[7:0];
    assign w_row = i_s_tdata[12:8];
    assign w_col = i_s_tdata[19:13];

    always_comb begin
        o_q_cmd.ch    = w_ch;
        o_q_cmd.row   = w_row;
        o_q_cmd.col   = w_col;
        o_q_cmd.rd_ok = (int'(w_row) < ROWS) && (int'(w_col) < COLUMNS);
        unique case (i_s_tuser)
            FN_PUT: begin
                priority if (w_ch == CH_NEWLINE) o_q_cmd.kind = K_NEWLINE;
                else if (w_ch == CH_RETURN)      o_q_cmd.kind = K_RETURN;
                else if (w_ch == CH_TAB)         o_q_cmd.kind = K_TAB;
                else                             o_q_cmd.kind = K_PUT;
            end
            FN_CLEAR: o_q_cmd.kind = K_CLEAR;
            FN_READ:  o_q_cmd.kind = K_READ;
            default:  o_q_cmd.kind = K_NOP;
        endcase
    end

    assign o_s_tready = !i_q_full && !i_init_busy;
    assign o_q_push   = i_s_tvalid && o_s_tready;

endmodule

>>> rtl/core/tcw_fifo.sv
// ----------------------------------------------------------------------------
// tcw_fifo: command queue
// Short queue of decoded commands between the front and back ends.
// ----------------------------------------------------------------------------
module tcw_fifo import tcw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_cmd             r_q [QDEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = r_rptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == CNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_q[r_rptr];

endmodule

>>> rtl/core/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back: screen store and cursor engine
// Executes commands against the cell memory: writes characters, moves the
// cursor, reads cells, sweeps the memory for scroll, clear and the reset fill,
// and registers each result word.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  t_cmd                  i_q_head,
    output logic                  o_q_pop,
    output logic                  o_init_busy,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata
);

    localparam int CELLS       = ROWS * COLUMNS;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int COL_W       = $clog2(COLUMNS + TAB_STEP);
    localparam int ROW_W       = $clog2(ROWS + 1);
    localparam int LAST_BASE   = CELLS - COLUMNS;
    localparam int SCROLL_LAST = CELLS - COLUMNS - 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCROLL,
        S_FILL,
        S_RDATA,
        S_DONE
    } t_state;

    logic [CELL_W-1:0] r_mem [CELLS];

    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COLOR_W-1:0] r_fg, n_fg;
    logic [COLOR_W-1:0] r_bg, n_bg;
    logic [ADDR_W-1:0]  r_sweep, n_sweep;
    logic [CELL_W-1:0]  r_fill_data, n_fill_data;
    logic               r_fill_res, n_fill_res;
    logic               r_we, n_we;
    logic               r_wcopy, n_wcopy;
    logic [ADDR_W-1:0]  r_waddr, n_waddr;
    logic [CELL_W-1:0]  r_wdata, n_wdata;
    logic [CELL_W-1:0]  r_rdata;
    logic               r_res_scr, n_res_scr;
    logic [CELL_W-1:0]  r_res_cell, n_res_cell;
    logic               r_ovalid, n_ovalid;
    logic [M_TDATA_W-1:0] r_odata, n_odata;

    logic               w_re;
    logic [ADDR_W-1:0]  w_raddr;
    logic [CELL_W-1:0]  w_blank;
    logic [ADDR_W-1:0]  w_put_addr;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [COL_W-1:0]   w_col_a;
    logic [ROW_W-1:0]   w_row_a;
    logic [COL_W-1:0]   w_col_b;
    logic [ROW_W-1:0]   w_row_b;
    logic               w_scroll;

    assign w_blank    = {r_bg, r_fg, CH_SPACE};
    assign w_put_addr = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
    assign w_rd_addr  = ADDR_W'(i_q_head.row) * ADDR_W'(COLUMNS) + ADDR_W'(i_q_head.col);
    assign o_q_pop    = (r_state == S_IDLE) && !i_q_empty && !r_we;
    assign o_init_busy = (r_state == S_FILL) && !r_fill_res;

    // cursor move for a put, newline, return or tab, then row wrap, then scroll
    always_comb begin
        w_col_a = r_col;
        w_row_a = r_row;
        unique case (i_q_head.kind)
            K_NEWLINE: begin
                w_col_a = '0;
                w_row_a = r_row + ROW_W'(1);
            end
            K_RETURN: w_col_a = '0;
            K_TAB:    w_col_a = (r_col + COL_W'(TAB_STEP)) & ~COL_W'(TAB_STEP - 1);
            K_PUT:    w_col_a = r_col + COL_W'(1);
            default:  w_col_a = r_col;
        endcase
        w_col_b = w_col_a;
        w_row_b = w_row_a;
        if (w_col_a >= COL_W'(COLUMNS)) begin
            w_col_b = '0;
            w_row_b = w_row_a + ROW_W'(1);
        end
        w_scroll = (w_row_b >= ROW_W'(ROWS));
        if (w_scroll) begin
            w_row_b = ROW_W'(ROWS - 1);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_fg        = r_fg;
        n_bg        = r_bg;
        n_sweep     = r_sweep;
        n_fill_data = r_fill_data;
        n_fill_res  = r_fill_res;
        n_we        = 1'b0;
        n_wcopy     = 1'b0;
        n_waddr     = r_waddr;
        n_wdata     = r_wdata;
        n_res_scr   = r_res_scr;
        n_res_cell  = r_res_cell;
        n_ovalid    = r_ovalid;
        n_odata     = r_odata;
        w_re        = 1'b0;
        w_raddr     = r_sweep + ADDR_W'(COLUMNS);

        if (i_cfg_valid) begin
            if (i_cfg_index == REG_FG) begin
                n_fg = i_cfg_data[COLOR_W-1:0];
            end else if (i_cfg_index == REG_BG) begin
                n_bg = i_cfg_data[COLOR_W-1:0];
            end
        end

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (o_q_pop) begin
                    n_res_scr  = 1'b0;
                    n_res_cell = '0;
                    unique case (i_q_head.kind)
                        K_PUT, K_NEWLINE, K_RETURN, K_TAB: begin
                            if (i_q_head.kind == K_PUT) begin
                                n_we    = 1'b1;
                                n_waddr = w_put_addr;
                                n_wdata = {r_bg, r_fg, i_q_head.ch};
                            end
                            n_col     = w_col_b;
                            n_row     = w_row_b;
                            n_res_scr = w_scroll;
                            n_sweep   = '0;
                            n_state   = w_scroll ? S_SCROLL : S_DONE;
                        end
                        K_CLEAR: begin
                            n_col       = '0;
                            n_row       = '0;
                            n_sweep     = '0;
                            n_fill_data = w_blank;
                            n_fill_res  = 1'b1;
                            n_state     = S_FILL;
                        end
                        K_READ: begin
                            if (i_q_head.rd_ok) begin
                                w_re    = 1'b1;
                                w_raddr = w_rd_addr;
                                n_state = S_RDATA;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SCROLL: begin
                // read one row below, write back on the following edge
                w_re    = 1'b1;
                n_we    = 1'b1;
                n_wcopy = 1'b1;
                n_waddr = r_sweep;
                if (r_sweep == ADDR_W'(SCROLL_LAST)) begin
                    n_sweep     = ADDR_W'(LAST_BASE);
                    n_fill_data = w_blank;
                    n_fill_res  = 1'b1;
                    n_state     = S_FILL;
                end else begin
                    n_sweep = r_sweep + ADDR_W'(1);
                end
            end
            S_FILL: begin
                n_we    = 1'b1;
                n_waddr = r_sweep;
                n_wdata = r_fill_data;
                if (r_sweep == ADDR_W'(CELLS - 1)) begin
                    n_state = r_fill_res ? S_DONE : S_IDLE;
                end else begin
                    n_sweep = r_sweep + ADDR_W'(1);
                end
            end
            S_RDATA: begin
                n_res_cell = r_rdata;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {3'b000, r_res_cell[15:8], r_res_cell[7:0], r_res_scr,
                                5'(r_row), 7'(r_col)};
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_col       <= '0;
            r_row       <= '0;
            r_fg        <= FG_RESET;
            r_bg        <= BG_RESET;
            r_sweep     <= '0;
            r_fill_data <= '0;
            r_fill_res  <= 1'b0;
            r_we        <= 1'b0;
            r_wcopy     <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_fg        <= n_fg;
            r_bg        <= n_bg;
            r_sweep     <= n_sweep;
            r_fill_data <= n_fill_data;
            r_fill_res  <= n_fill_res;
            r_we        <= n_we;
            r_wcopy     <= n_wcopy;
            r_ovalid    <= n_ovalid;
        end
        r_waddr    <= n_waddr;
        r_wdata    <= n_wdata;
        r_res_scr  <= n_res_scr;
        r_res_cell <= n_res_cell;
        r_odata    <= n_odata;
    end

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem[r_waddr] <= r_wcopy ? r_rdata : r_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

`ifndef SYNTHESIS
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < COL_W'(COLUMNS)) && (r_row < ROW_W'(ROWS)))
        else $error("cursor outside the screen");

    a_scroll_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL) |-> (r_col == '0))
        else $error("scroll with cursor not at column zero");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odata[12]) |-> (r_odata[11:7] == 5'(ROWS - 1)))
        else $error("scrolled result not on last row");

    a_copy_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_we && r_wcopy) |-> ($past(r_state) == S_SCROLL))
        else $error("row copy write outside scroll");
`endif

endmodule

>>> rtl/core/text_console_writer_top.sv
// Order of work: an accepted word is registered in the command queue; the back
// end pops it and loads its result into the result register. A read adds the
// cell read from the screen memory. Clear and a put that scrolls add the sweep
// that moves or blanks one cell of the screen memory per cycle.
// The queue keeps taking input words while it is not full; the back end works on one command at a time.
// Reset: synchronous; a fill pass zeroes the screen, s_tready low.
// ----------------------------------------------------------------------------
// text_console_writer_top: character-cell text console writer
// Front end decodes input words into a short queue; back end runs them
// against the screen memory and cursor and returns one result word each.
// ----------------------------------------------------------------------------
module text_console_writer_top import tcw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,  // char_code[7:0], read_row[12:8], read_col[19:13]
    input  logic [FUNC_W-1:0]     i_s_tuser,  // func[1:0]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,  // cursor_col_out[6:0], cursor_row_out[11:7],
                                              // scrolled[12], cell_char[20:13], cell_attr[28:21]
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_push_cmd;
    t_cmd w_head;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    logic w_init_busy;

    assign o_cfg_ready = 1'b1;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_init_busy (w_init_busy),
        .i_q_full    (w_full),
        .o_q_push    (w_push),
        .o_q_cmd     (w_push_cmd)
    );

    tcw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_empty),
        .i_q_head    (w_head),
        .o_q_pop     (w_pop),
        .o_init_busy (w_init_busy),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule
